FILE: design/masp_pkg.sv
// ----------------------------------------------------------------------------
// masp_pkg: shared types and widths for the step/direction pulse generator
// Field widths, lane command and lane status structs.
// ----------------------------------------------------------------------------
package masp_pkg;

  localparam int DELAY_W  = 20;  // edge spacing and elapsed time, microseconds
  localparam int PEND_W   = 11;  // pending edge count
  localparam int STEPS_W  = 10;  // step count field
  localparam int FRAME_W  = 10;  // frame length field
  localparam int COUNT_W  = 2;   // axis count field
  localparam int PINS_W   = 3;   // axes shown on the result pins
  localparam int CNT_W    = $clog2(DELAY_W);

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  typedef struct packed {
    logic               start;
    logic               load;
    logic [DELAY_W-1:0] frame_us;
    logic [STEPS_W-1:0] steps;   // zero for axes not commanded
    logic               sign;
  } lane_cmd_t;

  typedef struct packed {
    logic step;
    logic dir;
    logic busy;
    logic working;
  } lane_status_t;

endpackage

FILE: design/multi_axis_step_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// multi_axis_step_pulse_generator_core: step/direction generator top level
// Parallel axis lanes driven by tick and load items, merged into one result.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): action 0 is a one microsecond tick,
// action 1 loads a frame (frame_ms, axis_count, steps_*, sign_*).
// Output channel (out_valid/out_ready): one result per item with the STEP,
// DIR and busy levels of every shown axis after that item.
// Each axis is a lane of its own; all lanes work on an item at once.
// A tick updates the lanes as it is accepted and its result is then loaded
// into the output register. A load runs a restoring divider in every lane
// with a nonzero commanded step count (frame microseconds over twice the
// step count); its result is loaded once every divider is done.
// One item is in work at a time; the next is taken once the previous
// result sits in the output register, even while it waits for transfer.
// Reset clears all axes: STEP and DIR low, nothing pending.
// If out_ready stays low the result holds and in_ready stays low after
// the following item.
// ----------------------------------------------------------------------------
module multi_axis_step_pulse_generator_core #(
  parameter int AXES         = 3,
  parameter int TICKS_PER_MS = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [masp_pkg::FRAME_W-1:0]  frame_ms,
  input  logic [masp_pkg::COUNT_W-1:0]  axis_count,
  input  logic [masp_pkg::STEPS_W-1:0]  steps_a,
  input  logic [masp_pkg::STEPS_W-1:0]  steps_b,
  input  logic [masp_pkg::STEPS_W-1:0]  steps_c,
  input  logic                          sign_a,
  input  logic                          sign_b,
  input  logic                          sign_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [masp_pkg::PINS_W-1:0]   step_pins,
  output logic [masp_pkg::PINS_W-1:0]   dir_pins,
  output logic [masp_pkg::PINS_W-1:0]   busy_axes
);
  import masp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state;
  logic               accept;
  logic               merge_load;
  logic [DELAY_W-1:0] frame_us;
  logic [AXES-1:0]    working_v;
  logic [STEPS_W-1:0] steps_in [PINS_W];
  logic [PINS_W-1:0]  sign_in;

  lane_cmd_t    cmd    [AXES];
  lane_status_t status [AXES];

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  // the lanes hold their levels until the output register is free
  assign merge_load = (state == ST_RUN) && !(|working_v) && (!out_valid || out_ready);
  assign frame_us   = DELAY_W'(frame_ms) * DELAY_W'(TICKS_PER_MS);

  assign steps_in[0] = steps_a;
  assign steps_in[1] = steps_b;
  assign steps_in[2] = steps_c;
  assign sign_in     = {sign_c, sign_b, sign_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_RUN;
        ST_RUN:  if (merge_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    always_comb begin
      cmd[i].start    = accept;
      cmd[i].load     = action;
      cmd[i].frame_us = frame_us;
      cmd[i].steps    = '0;
      cmd[i].sign     = 1'b0;
      // axes without a field, or beyond the commanded count, are stopped
      if (i < PINS_W) begin
        if (COUNT_W'(i) < axis_count) begin
          cmd[i].steps = steps_in[i];
          cmd[i].sign  = sign_in[i];
        end
      end
    end

    masp_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd[i]),
      .status (status[i])
    );

    assign working_v[i] = status[i].working;
  end

  masp_merge #(
    .AXES (AXES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (merge_load),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .step_pins (step_pins),
    .dir_pins  (dir_pins),
    .busy_axes (busy_axes)
  );

`ifndef SYNTHESIS
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted while previous item still in work");

  a_step_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((step_pins & ~busy_axes) == '0))
    else $error("STEP high on an axis with nothing pending");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN))
    else $error("result appeared without an item in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    merge_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");
`endif

endmodule

FILE: design/masp_div.sv
// ----------------------------------------------------------------------------
// masp_div: iterative restoring divider
// Frame microseconds over pending edges, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module masp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [masp_pkg::DELAY_W-1:0] dividend,
  input  logic [masp_pkg::PEND_W-1:0]  divisor,
  output logic                        done,
  output logic [masp_pkg::DELAY_W-1:0] quotient
);
  import masp_pkg::*;

  logic [PEND_W-1:0]  rem;
  logic [PEND_W-1:0]  dsor;
  logic [DELAY_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic [PEND_W:0]    rem_sh;
  logic [PEND_W:0]    diff;

  assign rem_sh   = {rem, quo[DELAY_W-1]};
  assign diff     = rem_sh - {1'b0, dsor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DELAY_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      dsor <= divisor;
      rem  <= '0;
    end else if (run) begin
      if (!diff[PEND_W]) begin
        rem <= diff[PEND_W-1:0];
        quo <= {quo[DELAY_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[PEND_W-1:0];
        quo <= {quo[DELAY_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/masp_lane.sv
// ----------------------------------------------------------------------------
// masp_lane: one axis
// Holds the axis timing state, runs ticks and loads with its own divider.
// ----------------------------------------------------------------------------
module masp_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  masp_pkg::lane_cmd_t    cmd,
  output masp_pkg::lane_status_t status
);
  import masp_pkg::*;

  logic [PEND_W-1:0]  pending;
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] elapsed;
  logic               step;
  logic               dir;
  logic               working;
  logic               sign_hold;
  logic [PEND_W-1:0]  edges_hold;

  logic [PEND_W-1:0]  edges;
  logic [DELAY_W-1:0] elapsed_inc;
  logic               div_start;
  logic               div_done;
  logic [DELAY_W-1:0] div_quo;

  assign edges       = {cmd.steps, 1'b0};
  assign elapsed_inc = (elapsed < DELAY_MAX) ? elapsed + 1'b1 : elapsed;
  assign div_start   = cmd.start && cmd.load && (cmd.steps != '0);

  masp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cmd.frame_us),
    .divisor  (edges),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      delay   <= '0;
      elapsed <= '0;
      step    <= 1'b0;
      dir     <= 1'b0;
      working <= 1'b0;
    end else if (div_done) begin
      delay   <= div_quo;
      elapsed <= '0;
      dir     <= sign_hold;
      step    <= 1'b1;
      pending <= edges_hold - 1'b1;
      working <= 1'b0;
    end else if (cmd.start) begin
      if (cmd.load) begin
        step <= 1'b0;
        if (div_start) begin
          working <= 1'b1;
        end else begin
          pending <= '0;
        end
      end else if (pending != '0) begin
        // tick: advance and fire an edge once the spacing is reached
        if (elapsed_inc >= delay) begin
          step    <= ~pending[0];
          pending <= pending - 1'b1;
          elapsed <= elapsed_inc - delay;
        end else begin
          elapsed <= elapsed_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      sign_hold  <= cmd.sign;
      edges_hold <= edges;
    end
  end

  assign status.step    = step;
  assign status.dir     = dir;
  assign status.busy    = (pending != '0);
  assign status.working = working;

endmodule

FILE: design/masp_merge.sv
// ----------------------------------------------------------------------------
// masp_merge: result register
// Gathers pin levels of all lanes into one result and holds it for transfer.
// ----------------------------------------------------------------------------
module masp_merge #(
  parameter int AXES = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  masp_pkg::lane_status_t        status [AXES],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [masp_pkg::PINS_W-1:0]   step_pins,
  output logic [masp_pkg::PINS_W-1:0]   dir_pins,
  output logic [masp_pkg::PINS_W-1:0]   busy_axes
);
  import masp_pkg::*;

  logic [PINS_W-1:0] step_v;
  logic [PINS_W-1:0] dir_v;
  logic [PINS_W-1:0] busy_v;

  always_comb begin
    step_v = '0;
    dir_v  = '0;
    busy_v = '0;
    for (int j = 0; j < PINS_W; j++) begin
      if (j < AXES) begin
        step_v[j] = status[j].step;
        dir_v[j]  = status[j].dir;
        busy_v[j] = status[j].busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step_pins <= step_v;
      dir_pins  <= dir_v;
      busy_axes <= busy_v;
    end
  end

endmodule

FILE: verif/multi_axis_step_pulse_generator_core_tb.sv
// ----------------------------------------------------------------------------
// multi_axis_step_pulse_generator_core_tb: self-checking bench for the core
// Drives tick and load transfers with random gaps and output stalls, predicts
// STEP/DIR/busy levels per item and compares every result in order.
// ----------------------------------------------------------------------------
module multi_axis_step_pulse_generator_core_tb;
  import masp_pkg::*;

  localparam int   NAX          = 3;
  localparam logic ACT_TICK     = 1'b0;
  localparam logic ACT_LOAD     = 1'b1;
  localparam int   US_PER_MS    = 1000;
  localparam int   RUN_LIMIT    = 10_000_000;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   PHASE_ITEMS  = 460;

  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] frame_ms;
    logic [COUNT_W-1:0] axis_count;
    logic [STEPS_W-1:0] steps_a;
    logic [STEPS_W-1:0] steps_b;
    logic [STEPS_W-1:0] steps_c;
    logic               sign_a;
    logic               sign_b;
    logic               sign_c;
  } frame_item_t;

  typedef struct packed {
    logic [PINS_W-1:0] step;
    logic [PINS_W-1:0] dir;
    logic [PINS_W-1:0] busy;
  } pin_state_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               action     = ACT_TICK;
  logic [FRAME_W-1:0] frame_ms   = '0;
  logic [COUNT_W-1:0] axis_count = '0;
  logic [STEPS_W-1:0] steps_a    = '0;
  logic [STEPS_W-1:0] steps_b    = '0;
  logic [STEPS_W-1:0] steps_c    = '0;
  logic               sign_a     = 1'b0;
  logic               sign_b     = 1'b0;
  logic               sign_c     = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [PINS_W-1:0]  step_pins;
  logic [PINS_W-1:0]  dir_pins;
  logic [PINS_W-1:0]  busy_axes;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_cnt       = 0;
  int hold_left     = 0;
  logic hold_req    = 1'b0;

  pin_state_t pins_expected_q[$];

  // axis state mirror
  logic [PEND_W-1:0]  axis_pend    [NAX];
  logic [DELAY_W-1:0] axis_spacing [NAX];
  logic [DELAY_W-1:0] axis_elapsed [NAX];
  logic               axis_step    [NAX];
  logic               axis_dir     [NAX];

  multi_axis_step_pulse_generator_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .frame_ms   (frame_ms),
    .axis_count (axis_count),
    .steps_a    (steps_a),
    .steps_b    (steps_b),
    .steps_c    (steps_c),
    .sign_a     (sign_a),
    .sign_b     (sign_b),
    .sign_c     (sign_c),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .step_pins  (step_pins),
    .dir_pins   (dir_pins),
    .busy_axes  (busy_axes)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < NAX; i++) begin
      axis_pend[i]    = '0;
      axis_spacing[i] = '0;
      axis_elapsed[i] = '0;
      axis_step[i]    = 1'b0;
      axis_dir[i]     = 1'b0;
    end
  end

  // Advance the axis mirror by one item and return the pin levels after it.
  task automatic advance_axes(input frame_item_t it, output pin_state_t res);
    logic [DELAY_W-1:0] frame_us;
    logic [STEPS_W-1:0] steps;
    logic               sgn;
    logic [PEND_W-1:0]  edges;
    if (it.action == ACT_LOAD) begin
      frame_us = DELAY_W'(int'(it.frame_ms) * US_PER_MS);
      for (int i = 0; i < NAX; i++) begin
        axis_step[i] = 1'b0;
        steps = '0;
        sgn   = 1'b0;
        if (i < int'(it.axis_count)) begin
          case (i)
            0: begin steps = it.steps_a; sgn = it.sign_a; end
            1: begin steps = it.steps_b; sgn = it.sign_b; end
            default: begin steps = it.steps_c; sgn = it.sign_c; end
          endcase
        end
        if (steps != 0) begin
          edges           = PEND_W'({steps, 1'b0});
          axis_spacing[i] = frame_us / edges;
          axis_elapsed[i] = '0;
          axis_dir[i]     = sgn;
          axis_step[i]    = 1'b1;
          axis_pend[i]    = edges - 1'b1;
        end else begin
          axis_pend[i] = '0;
        end
      end
    end else begin
      for (int i = 0; i < NAX; i++) begin
        if (axis_pend[i] != 0) begin
          if (axis_elapsed[i] != DELAY_MAX) axis_elapsed[i] = axis_elapsed[i] + 1'b1;
          if (axis_elapsed[i] >= axis_spacing[i]) begin
            // odd count: falling edge, even count: rising edge
            axis_step[i]    = ~axis_pend[i][0];
            axis_pend[i]    = axis_pend[i] - 1'b1;
            axis_elapsed[i] = axis_elapsed[i] - axis_spacing[i];
          end
        end
      end
    end
    for (int i = 0; i < PINS_W; i++) begin
      res.step[i] = axis_step[i];
      res.dir[i]  = axis_dir[i];
      res.busy[i] = (axis_pend[i] != 0);
    end
  endtask

  // Offer one item after a random gap; valid holds until the transfer.
  task automatic send_item(input frame_item_t it);
    pin_state_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= it.action;
    frame_ms   <= it.frame_ms;
    axis_count <= it.axis_count;
    steps_a    <= it.steps_a;
    steps_b    <= it.steps_b;
    steps_c    <= it.steps_c;
    sign_a     <= it.sign_a;
    sign_b     <= it.sign_b;
    sign_c     <= it.sign_c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_axes(it, res);
    pins_expected_q.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pins_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic frame_item_t junk_item();
    frame_item_t it;
    it.action     = 1'($urandom);
    it.frame_ms   = FRAME_W'($urandom);
    it.axis_count = COUNT_W'($urandom);
    it.steps_a    = STEPS_W'($urandom);
    it.steps_b    = STEPS_W'($urandom);
    it.steps_c    = STEPS_W'($urandom);
    it.sign_a     = 1'($urandom);
    it.sign_b     = 1'($urandom);
    it.sign_c     = 1'($urandom);
    return it;
  endfunction

  // Tick with random don't-care payload.
  function automatic frame_item_t tick_item();
    frame_item_t it;
    it = junk_item();
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic frame_item_t load_item(int fms, int cnt, int sa, int sb, int sc,
                                            logic [2:0] signs);
    frame_item_t it;
    it.action     = ACT_LOAD;
    it.frame_ms   = FRAME_W'(fms);
    it.axis_count = COUNT_W'(cnt);
    it.steps_a    = STEPS_W'(sa);
    it.steps_b    = STEPS_W'(sb);
    it.steps_c    = STEPS_W'(sc);
    it.sign_a     = signs[0];
    it.sign_b     = signs[1];
    it.sign_c     = signs[2];
    return it;
  endfunction

  function automatic int pick_steps(int lo, int hi);
    if ($urandom_range(99) < 10) return 0;
    return $urandom_range(hi, lo);
  endfunction

  // Loads mostly sized so that edges actually fire within a short tick run.
  function automatic frame_item_t random_load();
    frame_item_t it;
    int mode;
    it = junk_item();
    it.action = ACT_LOAD;
    mode = $urandom_range(99);
    if (mode >= 15) begin
      it.axis_count = ($urandom_range(99) < 5) ? '0 : COUNT_W'($urandom_range(3, 1));
      if (mode < 55) begin
        it.frame_ms = '0;
        it.steps_a  = STEPS_W'(pick_steps(1, 20));
        it.steps_b  = STEPS_W'(pick_steps(1, 20));
        it.steps_c  = STEPS_W'(pick_steps(1, 20));
      end else if (mode < 80) begin
        it.frame_ms = FRAME_W'(1);
        it.steps_a  = STEPS_W'(pick_steps(250, 1023));
        it.steps_b  = STEPS_W'(pick_steps(250, 1023));
        it.steps_c  = STEPS_W'(pick_steps(250, 1023));
      end else begin
        it.frame_ms = FRAME_W'($urandom_range(3, 2));
        it.steps_a  = STEPS_W'(pick_steps(500, 1023));
        it.steps_b  = STEPS_W'(pick_steps(500, 1023));
        it.steps_c  = STEPS_W'(pick_steps(500, 1023));
      end
    end
    return it;
  endfunction

  task automatic report_field(string name, logic [PINS_W-1:0] exp_v, logic [PINS_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pin_state_t exp_p;
    if (!rst && out_valid && out_ready) begin
      if (pins_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual step=%0h dir=%0h busy=%0h",
                 $time, step_pins, dir_pins, busy_axes);
        err_cnt++;
      end else begin
        exp_p = pins_expected_q.pop_front();
        report_field("step_pins", exp_p.step, step_pins);
        report_field("dir_pins", exp_p.dir, dir_pins);
        report_field("busy_axes", exp_p.busy, busy_axes);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_idle_after_reset();
    send_item(tick_item());
    send_item(tick_item());
    wait_drained();
  endtask

  task automatic test_load_extremes();
    send_item(load_item(1023, 3, 1023, 1023, 1023, 3'b111));
    send_item(tick_item());
    // zero frame: one edge per tick
    send_item(load_item(0, 3, 1, 1, 1, 3'b000));
    send_item(tick_item());
    send_item(tick_item());
    send_item(load_item(999, 3, 999, 999, 999, 3'b101));
    send_item(tick_item());
    wait_drained();
  endtask

  task automatic test_axis_count();
    // axes beyond the count stop, direction kept
    send_item(load_item(0, 1, 5, 7, 9, 3'b111));
    send_item(tick_item());
    // zero steps on a commanded axis
    send_item(load_item(0, 2, 4, 0, 9, 3'b010));
    send_item(tick_item());
    send_item(tick_item());
    send_item(load_item(0, 3, 0, 2, 1, 3'b100));
    send_item(tick_item());
    wait_drained();
  endtask

  task automatic test_stop_and_reload();
    send_item(load_item(1, 3, 300, 400, 500, 3'b011));
    send_item(tick_item());
    send_item(tick_item());
    // reload mid-frame drops all STEP pins first
    send_item(load_item(1, 3, 2, 3, 4, 3'b110));
    send_item(tick_item());
    // count zero stops everything
    send_item(load_item(0, 0, 7, 7, 7, 3'b111));
    send_item(tick_item());
    send_item(tick_item());
    wait_drained();
  endtask

  task automatic test_random_frames(int n_items);
    int sent;
    int n_ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        send_item(junk_item());
        sent++;
      end else begin
        send_item(random_load());
        sent++;
        n_ticks = $urandom_range(60, 1);
        repeat (n_ticks) begin
          send_item(tick_item());
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    send_item(random_load());
    repeat (15) send_item(tick_item());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 30;
    test_idle_after_reset();
    test_load_extremes();
    test_axis_count();
    test_stop_and_reload();
    send_idle_pct = 36;
    recv_idle_pct = 75;
    test_random_frames(PHASE_ITEMS);
    send_idle_pct = 75;
    recv_idle_pct = 36;
    test_random_frames(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(PHASE_ITEMS);
    test_backpressure();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: multi_axis_step_pulse_generator_core.f
design/masp_pkg.sv
design/masp_div.sv
design/masp_lane.sv
design/masp_merge.sv
design/multi_axis_step_pulse_generator_core.sv
verif/multi_axis_step_pulse_generator_core_tb.sv
